[hdl/mouse_look_camera_step_defines.svh]
// assertion macros shared by the camera block
`ifndef MOUSE_LOOK_CAMERA_STEP_DEFINES_SVH
`define MOUSE_LOOK_CAMERA_STEP_DEFINES_SVH

`ifndef SYNTHESIS
`define MLC_ASSERT(label, clk, rstn, prop) \
	label: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("camera assertion failed");
`define MLC_ASSERT_NEVER(label, clk, rstn, cond) \
	`MLC_ASSERT(label, clk, rstn, !(cond))
`else
`define MLC_ASSERT(label, clk, rstn, prop)
`define MLC_ASSERT_NEVER(label, clk, rstn, cond)
`endif

`endif

[hdl/mlc_pkg.sv]
package mlc_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
	localparam int ITER_W = $clog2(CORDIC_ITERS + 1);
	localparam int SHIFT_W = $clog2(ATAN_ENTRIES);
	localparam int ATAN_W = 26;

	// angles in 1/256 degree
	localparam int ANG_360 = 92160;
	localparam int ANG_180 = 46080;
	localparam int ANG_90 = 23040;

	localparam int XY_W = 34;
	localparam int Z_W = 30;
	localparam int CORDIC_GAIN = 652032874;
	localparam int Q14_ONE = 16384;

	localparam int SENS_W = 12;
	localparam int LIMIT_W = 15;
	localparam int SPEED_W = 16;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SENS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED = 2'd2;

	localparam int MUL_A_W = 40;
	localparam int MUL_B_W = 17;
	localparam int MUL_N_W = 5;

	localparam int DIV_CONST = 15625;
	localparam int DIV_BIAS = 7812;
	localparam int DIVIDEND_W = 35;
	localparam int QUOT_W = 21;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// atan(2^-i) in 2^-20 degree
	function automatic logic [ATAN_W-1:0] atan_val(input logic [SHIFT_W-1:0] idx);
		case (idx)
			5'd0: atan_val = 26'd47185920;
			5'd1: atan_val = 26'd27855475;
			5'd2: atan_val = 26'd14718068;
			5'd3: atan_val = 26'd7471121;
			5'd4: atan_val = 26'd3750058;
			5'd5: atan_val = 26'd1876857;
			5'd6: atan_val = 26'd938658;
			5'd7: atan_val = 26'd469357;
			5'd8: atan_val = 26'd234682;
			5'd9: atan_val = 26'd117342;
			5'd10: atan_val = 26'd58671;
			5'd11: atan_val = 26'd29335;
			5'd12: atan_val = 26'd14668;
			5'd13: atan_val = 26'd7334;
			5'd14: atan_val = 26'd3667;
			5'd15: atan_val = 26'd1833;
			5'd16: atan_val = 26'd917;
			5'd17: atan_val = 26'd458;
			5'd18: atan_val = 26'd229;
			5'd19: atan_val = 26'd115;
			5'd20: atan_val = 26'd57;
			5'd21: atan_val = 26'd29;
			5'd22: atan_val = 26'd14;
			5'd23: atan_val = 26'd7;
			default: atan_val = '0;
		endcase
	endfunction

endpackage

[hdl/mlc_item_if.sv]
interface mlc_item_if;
	logic valid;
	logic ready;
	logic kind;
	logic signed [15:0] cursor_x;
	logic signed [15:0] cursor_y;
	logic key_forward;
	logic key_back;
	logic key_left;
	logic key_right;
	logic [15:0] frame_time;

	modport source (
		output valid, kind, cursor_x, cursor_y, key_forward, key_back, key_left,
			key_right, frame_time,
		input ready
	);
	modport sink (
		input valid, kind, cursor_x, cursor_y, key_forward, key_back, key_left,
			key_right, frame_time,
		output ready
	);
endinterface

[hdl/mlc_result_if.sv]
interface mlc_result_if;
	logic valid;
	logic ready;
	logic signed [15:0] front_x;
	logic signed [15:0] front_y;
	logic signed [15:0] front_z;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;

	modport source (
		output valid, front_x, front_y, front_z, pos_x, pos_y, pos_z,
		input ready
	);
	modport sink (
		input valid, front_x, front_y, front_z, pos_x, pos_y, pos_z,
		output ready
	);
endinterface

[hdl/mlc_serial_mul.sv]
module mlc_serial_mul import mlc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [MUL_A_W-1:0] a,
	input logic [MUL_B_W-1:0] b,
	input logic [MUL_N_W-1:0] nbits,
	output unit_stat_t stat,
	output logic signed [MUL_A_W-1:0] p
);

	logic signed [MUL_A_W-1:0] a_q;
	logic signed [MUL_A_W-1:0] acc_q;
	logic [MUL_B_W-1:0] b_q;
	logic [MUL_N_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic signed [MUL_A_W-1:0] term;

	assign term = b_q[0] ? a_q : '0;

	// one multiplier bit a cycle, lsb first; the top bit carries negative weight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == MUL_N_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == MUL_N_W'(1))
				acc_q <= acc_q - term;
			else
				acc_q <= acc_q + term;
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign p = acc_q;

endmodule

[hdl/mlc_const_div.sv]
module mlc_const_div import mlc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [DIVIDEND_W-1:0] dividend,
	output unit_stat_t stat,
	output logic [QUOT_W-1:0] quotient
);

	localparam int CNT_W = $clog2(QUOT_W + 1);
	localparam logic [DIVIDEND_W-1:0] DSH_INIT = DIVIDEND_W'(DIV_CONST) << (QUOT_W - 1);

	logic [DIVIDEND_W-1:0] rem_q;
	logic [DIVIDEND_W-1:0] dsh_q;
	logic [QUOT_W-1:0] quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic fits;

	assign fits = rem_q >= dsh_q;

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= CNT_W'(QUOT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= DSH_INIT;
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits)
				rem_q <= rem_q - dsh_q;
			quot_q <= {quot_q[QUOT_W-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient = quot_q;

endmodule

[hdl/mlc_cordic.sv]
module mlc_cordic import mlc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [17:0] angle,
	output unit_stat_t stat,
	output logic signed [15:0] sin_v,
	output logic signed [15:0] cos_v
);

	localparam logic signed [17:0] A360 = 18'(ANG_360);
	localparam logic signed [17:0] A180 = 18'(ANG_180);
	localparam logic signed [17:0] A90 = 18'(ANG_90);
	localparam logic signed [XY_W-1:0] HALF = XY_W'(32768);
	localparam logic signed [XY_W-1:0] LIM = XY_W'(Q14_ONE);

	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0] z_q;
	logic flip_q;
	logic [ITER_W-1:0] ii_q;
	logic busy_q;
	logic done_q;

	logic signed [17:0] a_wrap;
	logic signed [17:0] a_fold;
	logic flip_in;
	logic [SHIFT_W-1:0] sh;
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [Z_W-1:0] at;
	logic signed [XY_W-1:0] rx;
	logic signed [XY_W-1:0] ry;
	logic signed [15:0] cx;
	logic signed [15:0] cy;

	// bring the angle into (-180, 180], then into [-90, 90] with a sign flip
	always_comb begin
		a_wrap = angle;
		if (angle > A180)
			a_wrap = angle - A360;
		else if (angle <= -A180)
			a_wrap = angle + A360;
		a_fold = a_wrap;
		flip_in = 1'b0;
		if (a_wrap > A90) begin
			a_fold = a_wrap - A180;
			flip_in = 1'b1;
		end else if (a_wrap < -A90) begin
			a_fold = a_wrap + A180;
			flip_in = 1'b1;
		end
	end

	assign sh = SHIFT_W'(ii_q);
	assign xs = x_q >>> sh;
	assign ys = y_q >>> sh;
	assign at = Z_W'(atan_val(sh));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ii_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			ii_q <= '0;
		end else if (busy_q) begin
			ii_q <= ii_q + 1'b1;
			if (ii_q == ITER_W'(CORDIC_ITERS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= XY_W'(CORDIC_GAIN);
			y_q <= '0;
			z_q <= {a_fold, 12'b0};
			flip_q <= flip_in;
		end else if (busy_q) begin
			if (!z_q[Z_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	// round half up to q1.14 and clamp to one
	always_comb begin
		rx = (x_q + HALF) >>> 16;
		ry = (y_q + HALF) >>> 16;
		if (rx > LIM)
			rx = LIM;
		else if (rx < -LIM)
			rx = -LIM;
		if (ry > LIM)
			ry = LIM;
		else if (ry < -LIM)
			ry = -LIM;
		cx = rx[15:0];
		cy = ry[15:0];
	end

	assign cos_v = flip_q ? -cx : cx;
	assign sin_v = flip_q ? -cy : cy;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[hdl/mouse_look_camera_step.sv]
// Fly camera with mouse look. A cursor word (kind 0) turns the cursor step into yaw and
// pitch and rebuilds the view vector; a tick word (kind 1) moves the position along the
// view and right vectors for each held key. Every word gives one result word. All
// products, rotations and the division run through a bit-serial multiplier (one
// multiplier bit a cycle), a CORDIC that does one rotation a cycle and a divider by 15625
// that yields one quotient bit a cycle. A cursor word runs two products, a 13-step yaw
// wrap, two CORDIC runs and two more products; a tick runs one CORDIC run, six products,
// the division and an apply pass over each key and axis. One word is in flight at a time;
// a finished result waits in the output register while the next word is taken.
`include "mouse_look_camera_step_defines.svh"

module mouse_look_camera_step import mlc_pkg::*; (
	input logic clk,
	input logic arst_n,
	mlc_item_if.sink item,
	mlc_result_if.source result,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE, S_YMUL, S_YMUL_W, S_YMOD, S_PMUL, S_PMUL_W, S_CYAW, S_CYAW_W,
		S_CPIT, S_CPIT_W, S_FX, S_FX_W, S_FZ, S_FZ_W, S_TMUL, S_TMUL_W,
		S_DIV_W, S_DMUL, S_DMUL_W, S_APPLY, S_DONE
	} state_t;

	localparam int DD_W = 24;
	localparam int YMOD_STEPS = 13;
	localparam logic [31:0] YMOD_TOP = 32'(ANG_360) << (YMOD_STEPS - 1);
	localparam logic signed [15:0] FRONT_Z_RESET = -16'(Q14_ONE);
	localparam logic signed [31:0] POS_Z_RESET = 32'sd196608;
	localparam logic signed [MUL_A_W-1:0] RND14 = MUL_A_W'(8192);
	localparam logic signed [33:0] POS_MAX = 34'sd2147483647;
	localparam logic signed [33:0] POS_MIN = -34'sd2147483648;

	state_t state_q;

	logic [SENS_W-1:0] sens_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [SPEED_W-1:0] speed_q;

	logic kind_q;
	logic [3:0] keys_q;
	logic [15:0] ft_q;
	logic signed [16:0] dx_q;
	logic signed [16:0] dy_q;
	logic signed [15:0] prev_x_q;
	logic signed [15:0] prev_y_q;
	logic awaiting_q;
	logic [16:0] yaw_q;
	logic signed [15:0] pitch_q;
	logic signed [15:0] view_q [3];
	logic signed [31:0] pos_q [3];
	logic signed [15:0] sy_q;
	logic signed [15:0] cyw_q;
	logic signed [15:0] sp_q;
	logic signed [15:0] cp_q;
	logic [31:0] ang_q;
	logic [31:0] dsub_q;
	logic [3:0] mcnt_q;
	logic [QUOT_W-1:0] dist_q;
	logic signed [DD_W-1:0] dd_q [5];
	logic [2:0] didx_q;
	logic [1:0] kk_q;
	logic [1:0] ax_q;
	logic res_valid_q;
	logic signed [15:0] out_front_q [3];
	logic signed [31:0] out_pos_q [3];

	logic mul_start;
	logic signed [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_N_W-1:0] mul_n;
	logic signed [MUL_A_W-1:0] mul_p;
	unit_stat_t mul_stat;
	logic cor_start;
	logic signed [17:0] cor_angle;
	logic signed [15:0] cor_sin;
	logic signed [15:0] cor_cos;
	unit_stat_t cor_stat;
	logic div_start;
	logic [DIVIDEND_W-1:0] div_in;
	logic [QUOT_W-1:0] div_q;
	unit_stat_t div_stat;

	logic signed [15:0] dir_sel;
	logic signed [MUL_A_W-1:0] p_rnd;
	logic signed [31:0] yaw_new;
	logic signed [31:0] pitch_sum;
	logic signed [31:0] lim_s;
	logic signed [15:0] pitch_new;
	logic signed [DD_W-1:0] dsel;
	logic dneg;
	logic signed [33:0] pos_sum;
	logic signed [31:0] pos_sat;
	logic key_on;
	logic in_fire;
	logic out_fire;
	logic res_load;

	assign in_fire = item.valid && item.ready;
	assign out_fire = result.valid && result.ready;
	assign item.ready = (state_q == S_IDLE);
	assign res_load = (state_q == S_DONE) && (!res_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q <= SENS_W'(26);
			limit_q <= LIMIT_W'(22784);
			speed_q <= SPEED_W'(640);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SENS: sens_q <= cfg_data[SENS_W-1:0];
				REG_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				REG_SPEED: speed_q <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (didx_q)
			3'd0: dir_sel = view_q[0];
			3'd1: dir_sel = view_q[1];
			3'd2: dir_sel = view_q[2];
			3'd3: dir_sel = -sy_q;
			default: dir_sel = cyw_q;
		endcase
	end

	// unit operands follow the state
	always_comb begin
		mul_start = 1'b0;
		mul_a = '0;
		mul_b = '0;
		mul_n = '0;
		cor_start = 1'b0;
		cor_angle = '0;
		unique case (state_q)
			S_YMUL: begin
				mul_start = 1'b1;
				mul_a = MUL_A_W'(dx_q);
				mul_b = MUL_B_W'(sens_q);
				mul_n = MUL_N_W'(SENS_W + 1);
			end
			S_PMUL: begin
				mul_start = 1'b1;
				mul_a = MUL_A_W'(dy_q);
				mul_b = MUL_B_W'(sens_q);
				mul_n = MUL_N_W'(SENS_W + 1);
			end
			S_FX: begin
				mul_start = 1'b1;
				mul_a = MUL_A_W'(cyw_q);
				mul_b = MUL_B_W'(cp_q);
				mul_n = MUL_N_W'(MUL_B_W);
			end
			S_FZ: begin
				mul_start = 1'b1;
				mul_a = MUL_A_W'(sy_q);
				mul_b = MUL_B_W'(cp_q);
				mul_n = MUL_N_W'(MUL_B_W);
			end
			S_TMUL: begin
				mul_start = 1'b1;
				mul_a = MUL_A_W'($signed({1'b0, speed_q}));
				mul_b = MUL_B_W'(ft_q);
				mul_n = MUL_N_W'(MUL_B_W);
			end
			S_DMUL: begin
				mul_start = 1'b1;
				mul_a = MUL_A_W'($signed({1'b0, dist_q}));
				mul_b = MUL_B_W'(dir_sel);
				mul_n = MUL_N_W'(MUL_B_W);
			end
			S_CYAW: begin
				cor_start = 1'b1;
				cor_angle = $signed({1'b0, yaw_q});
			end
			S_CPIT: begin
				cor_start = 1'b1;
				cor_angle = 18'(pitch_q);
			end
			default: ;
		endcase
	end

	assign div_start = (state_q == S_TMUL_W) && mul_stat.done;
	assign div_in = DIVIDEND_W'({mul_p[32:0], 2'b00}) + DIVIDEND_W'(DIV_BIAS);

	mlc_serial_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.nbits(mul_n), .stat(mul_stat), .p(mul_p)
	);

	mlc_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .angle(cor_angle),
		.stat(cor_stat), .sin_v(cor_sin), .cos_v(cor_cos)
	);

	mlc_const_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_in),
		.stat(div_stat), .quotient(div_q)
	);

	always_comb begin
		p_rnd = (mul_p + RND14) >>> 14;
		yaw_new = $signed({15'b0, yaw_q}) + $signed(mul_p[31:0]);
		pitch_sum = 32'(pitch_q) + $signed(mul_p[31:0]);
		lim_s = $signed({17'b0, limit_q});
		if (pitch_sum > lim_s)
			pitch_new = lim_s[15:0];
		else if (pitch_sum < -lim_s)
			pitch_new = -lim_s[15:0];
		else
			pitch_new = pitch_sum[15:0];
	end

	// key order forward, back, left, right; left and right have no y part
	always_comb begin
		key_on = keys_q[kk_q];
		dneg = (kk_q == 2'd1) || (kk_q == 2'd2);
		if (kk_q[1]) begin
			if (ax_q == 2'd0)
				dsel = dd_q[3];
			else if (ax_q == 2'd2)
				dsel = dd_q[4];
			else
				dsel = '0;
		end else begin
			dsel = dd_q[3'(ax_q)];
		end
		pos_sum = 34'(pos_q[ax_q]) + (dneg ? -34'(dsel) : 34'(dsel));
		if (pos_sum > POS_MAX)
			pos_sat = POS_MAX[31:0];
		else if (pos_sum < POS_MIN)
			pos_sat = POS_MIN[31:0];
		else
			pos_sat = pos_sum[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			prev_x_q <= '0;
			prev_y_q <= '0;
			awaiting_q <= 1'b1;
			yaw_q <= 17'(ANG_360 - ANG_90);
			pitch_q <= '0;
			view_q[0] <= '0;
			view_q[1] <= '0;
			view_q[2] <= FRONT_Z_RESET;
			pos_q[0] <= '0;
			pos_q[1] <= '0;
			pos_q[2] <= POS_Z_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load)
				res_valid_q <= 1'b1;
			else if (out_fire)
				res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						kind_q <= item.kind;
						keys_q <= {item.key_right, item.key_left, item.key_back,
							item.key_forward};
						ft_q <= item.frame_time;
						if (!item.kind) begin
							if (awaiting_q) begin
								dx_q <= '0;
								dy_q <= '0;
							end else begin
								dx_q <= 17'(item.cursor_x) - 17'(prev_x_q);
								dy_q <= 17'(prev_y_q) - 17'(item.cursor_y);
							end
							prev_x_q <= item.cursor_x;
							prev_y_q <= item.cursor_y;
							awaiting_q <= 1'b0;
							state_q <= S_YMUL;
						end else begin
							state_q <= S_CYAW;
						end
					end
				end
				S_YMUL: state_q <= S_YMUL_W;
				S_YMUL_W: begin
					if (mul_stat.done) begin
						// a negative sum is lifted by a multiple of 360 degrees
						ang_q <= yaw_new[31] ? 32'(yaw_new) + YMOD_TOP : 32'(yaw_new);
						dsub_q <= YMOD_TOP;
						mcnt_q <= 4'(YMOD_STEPS - 1);
						state_q <= S_YMOD;
					end
				end
				S_YMOD: begin
					if (ang_q >= dsub_q)
						ang_q <= ang_q - dsub_q;
					dsub_q <= dsub_q >> 1;
					mcnt_q <= mcnt_q - 1'b1;
					if (mcnt_q == '0)
						state_q <= S_PMUL;
				end
				S_PMUL: begin
					yaw_q <= ang_q[16:0];
					state_q <= S_PMUL_W;
				end
				S_PMUL_W: begin
					if (mul_stat.done) begin
						pitch_q <= pitch_new;
						state_q <= S_CYAW;
					end
				end
				S_CYAW: state_q <= S_CYAW_W;
				S_CYAW_W: begin
					if (cor_stat.done) begin
						sy_q <= cor_sin;
						cyw_q <= cor_cos;
						state_q <= kind_q ? S_TMUL : S_CPIT;
					end
				end
				S_CPIT: state_q <= S_CPIT_W;
				S_CPIT_W: begin
					if (cor_stat.done) begin
						sp_q <= cor_sin;
						cp_q <= cor_cos;
						state_q <= S_FX;
					end
				end
				S_FX: state_q <= S_FX_W;
				S_FX_W: begin
					if (mul_stat.done) begin
						view_q[0] <= p_rnd[15:0];
						view_q[1] <= sp_q;
						state_q <= S_FZ;
					end
				end
				S_FZ: state_q <= S_FZ_W;
				S_FZ_W: begin
					if (mul_stat.done) begin
						view_q[2] <= p_rnd[15:0];
						state_q <= S_DONE;
					end
				end
				S_TMUL: state_q <= S_TMUL_W;
				S_TMUL_W: begin
					if (mul_stat.done)
						state_q <= S_DIV_W;
				end
				S_DIV_W: begin
					if (div_stat.done) begin
						dist_q <= div_q;
						didx_q <= '0;
						state_q <= S_DMUL;
					end
				end
				S_DMUL: state_q <= S_DMUL_W;
				S_DMUL_W: begin
					if (mul_stat.done) begin
						dd_q[didx_q] <= p_rnd[DD_W-1:0];
						didx_q <= didx_q + 1'b1;
						if (didx_q == 3'd4) begin
							kk_q <= '0;
							ax_q <= '0;
							state_q <= S_APPLY;
						end else begin
							state_q <= S_DMUL;
						end
					end
				end
				S_APPLY: begin
					if (key_on)
						pos_q[ax_q] <= pos_sat;
					if (ax_q == 2'd2) begin
						ax_q <= '0;
						kk_q <= kk_q + 1'b1;
						if (kk_q == 2'd3)
							state_q <= S_DONE;
					end else begin
						ax_q <= ax_q + 1'b1;
					end
				end
				S_DONE: begin
					if (res_load) begin
						out_front_q <= view_q;
						out_pos_q <= pos_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid = res_valid_q;
	assign result.front_x = out_front_q[0];
	assign result.front_y = out_front_q[1];
	assign result.front_z = out_front_q[2];
	assign result.pos_x = out_pos_q[0];
	assign result.pos_y = out_pos_q[1];
	assign result.pos_z = out_pos_q[2];

	`MLC_ASSERT(a_yaw_in_range, clk, arst_n, yaw_q < 17'(ANG_360))
	`MLC_ASSERT(a_one_word_in_flight, clk, arst_n, in_fire |=> !item.ready)
	`MLC_ASSERT_NEVER(a_units_exclusive, clk, arst_n, mul_stat.busy && cor_stat.busy)
	`MLC_ASSERT(a_mul_done_awaited, clk, arst_n, mul_stat.done |-> (state_q == S_YMUL_W ||
		state_q == S_PMUL_W || state_q == S_FX_W || state_q == S_FZ_W ||
		state_q == S_TMUL_W || state_q == S_DMUL_W))

endmodule

[tb/mlc_checker.sv]
`timescale 1ns / 100ps

module mlc_checker import mlc_pkg::*; (
	input logic clk,
	input logic arst_n,
	mlc_item_if item,
	mlc_result_if result,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	output int fail_count,
	output int pending
);

	typedef struct {
		longint f[6];
	} camera_out_t;

	camera_out_t camera_q[$];

	logic [SENS_W-1:0] sens;
	logic [LIMIT_W-1:0] limit;
	logic [SPEED_W-1:0] speed;
	int last_cx, last_cy;
	bit first_move;
	int yaw, pitch;
	int front[3];
	int pos[3];

	function automatic int round_q14(longint v);
		longint r;
		r = (v + 32768) >>> 16;
		if (r > Q14_ONE) r = Q14_ONE;
		if (r < -Q14_ONE) r = -Q14_ONE;
		return int'(r);
	endfunction

	function automatic int mul_q14(int a, int b);
		return int'((longint'(a) * b + 8192) >>> 14);
	endfunction

	function automatic int sat_add(int p, longint d);
		longint r;
		r = longint'(p) + d;
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return int'(r);
	endfunction

	task automatic rotate(input int ang, output int s, output int c);
		longint x, y, z, nx;
		bit flip;
		x = CORDIC_GAIN;
		y = 0;
		flip = 0;
		if (ang > ANG_180) ang -= ANG_360;
		if (ang <= -ANG_180) ang += ANG_360;
		if (ang > ANG_90) begin
			ang -= ANG_180;
			flip = 1;
		end else if (ang < -ANG_90) begin
			ang += ANG_180;
			flip = 1;
		end
		z = longint'(ang) * 4096;
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(atan_val(i[SHIFT_W-1:0]));
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(atan_val(i[SHIFT_W-1:0]));
			end
			x = nx;
		end
		c = round_q14(x);
		s = round_q14(y);
		if (flip) begin
			c = -c;
			s = -s;
		end
	endtask

	task automatic travel(input longint span, input int dir[3], input bit neg);
		longint d;
		for (int k = 0; k < 3; k++) begin
			d = (span * dir[k] + 8192) >>> 14;
			pos[k] = sat_add(pos[k], neg ? -d : d);
		end
	endtask

	task automatic take_word();
		camera_out_t e;
		longint yv, pv, lim, span;
		int cx, cy, sy, cyw, sp, cp;
		int right[3];
		if (!item.kind) begin
			cx = item.cursor_x;
			cy = item.cursor_y;
			lim = limit;
			if (first_move) begin
				last_cx = cx;
				last_cy = cy;
				first_move = 0;
			end
			yv = longint'(yaw) + longint'(cx - last_cx) * sens;
			pv = longint'(pitch) + longint'(last_cy - cy) * sens;
			last_cx = cx;
			last_cy = cy;
			yv = yv % ANG_360;
			if (yv < 0) yv += ANG_360;
			if (pv > lim) pv = lim;
			if (pv < -lim) pv = -lim;
			yaw = int'(yv);
			pitch = int'(pv);
			rotate(yaw, sy, cyw);
			rotate(pitch, sp, cp);
			front[0] = mul_q14(cyw, cp);
			front[1] = sp;
			front[2] = mul_q14(sy, cp);
		end else begin
			span = longint'((64'(speed) * item.frame_time * 4 + 7812) / 15625);
			rotate(yaw, sy, cyw);
			right[0] = -sy;
			right[1] = 0;
			right[2] = cyw;
			if (item.key_forward) travel(span, front, 0);
			if (item.key_back) travel(span, front, 1);
			if (item.key_left) travel(span, right, 1);
			if (item.key_right) travel(span, right, 0);
		end
		for (int k = 0; k < 3; k++) begin
			e.f[k] = longint'(16'(front[k]));
			e.f[k + 3] = longint'(32'(pos[k]));
		end
		camera_q.push_back(e);
	endtask

	task automatic check_word();
		camera_out_t e;
		longint got[6];
		got[0] = longint'(16'(result.front_x));
		got[1] = longint'(16'(result.front_y));
		got[2] = longint'(16'(result.front_z));
		got[3] = longint'(32'(result.pos_x));
		got[4] = longint'(32'(result.pos_y));
		got[5] = longint'(32'(result.pos_z));
		if (camera_q.size() == 0) begin
			$display("%0t: unexpected result word", $time);
			fail_count++;
		end else begin
			e = camera_q.pop_front();
			for (int k = 0; k < 6; k++)
				if (e.f[k] != got[k]) begin
					$display("%0t: field %0d expected %h actual %h", $time, k, e.f[k], got[k]);
					fail_count++;
				end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens = 26;
			limit = 22784;
			speed = 640;
			last_cx = 0;
			last_cy = 0;
			first_move = 1;
			yaw = 69120;
			pitch = 0;
			front = '{0, 0, -Q14_ONE};
			pos = '{0, 0, 196608};
			camera_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SENS: sens = cfg_data[SENS_W-1:0];
					REG_LIMIT: limit = cfg_data[LIMIT_W-1:0];
					REG_SPEED: speed = cfg_data[SPEED_W-1:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) check_word();
			if (item.valid && item.ready) take_word();
			pending = camera_q.size();
		end
	end

endmodule

[tb/tb_mouse_look_camera_step.sv]
`timescale 1ns / 100ps

module tb_mouse_look_camera_step;
	import mlc_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int fail_count, pending;
	bit calm;
	logic signed [15:0] cur_x, cur_y;

	mlc_item_if item_ch();
	mlc_result_if res_ch();

	mouse_look_camera_step dut (
		.clk(clk), .arst_n(arst_n), .item(item_ch), .result(res_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	mlc_checker u_checker (
		.clk(clk), .arst_n(arst_n), .item(item_ch), .result(res_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_ch.ready <= 0;
		else
			res_ch.ready <= calm || $urandom_range(99) >= 24;
	end

	task automatic send(input bit kind, input logic [15:0] cx, input logic [15:0] cy,
			input logic [3:0] keys, input logic [15:0] ft);
		while (!calm && $urandom_range(99) < 24) begin
			item_ch.valid <= 0;
			@(posedge clk);
		end
		item_ch.valid <= 1;
		item_ch.kind <= kind;
		item_ch.cursor_x <= cx;
		item_ch.cursor_y <= cy;
		{item_ch.key_forward, item_ch.key_back, item_ch.key_left, item_ch.key_right} <= keys;
		item_ch.frame_time <= ft;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic look(input logic [15:0] x, input logic [15:0] y);
		cur_x = x;
		cur_y = y;
		send(1'b0, x, y, 4'($urandom), 16'($urandom));
	endtask

	task automatic tick(input logic [3:0] keys, input logic [15:0] ft);
		send(1'b1, 16'($urandom), 16'($urandom), keys, ft);
	endtask

	// settle: wait for every outstanding word, then let the block go quiet
	task automatic settle();
		item_ch.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_all(input int s, input int l, input int v);
		set_reg(REG_SENS, CFG_W'(s));
		set_reg(REG_LIMIT, CFG_W'(l));
		set_reg(REG_SPEED, CFG_W'(v));
	endtask

	task automatic random_words(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 50) begin
				if ($urandom_range(99) < 80)
					look(16'(cur_x + $signed(16'($urandom_range(128))) - 64),
						16'(cur_y + $signed(16'($urandom_range(128))) - 64));
				else
					look(16'($urandom), 16'($urandom));
			end else if ($urandom_range(99) < 85) begin
				tick(4'($urandom), 16'($urandom_range(40000)));
			end else begin
				tick(4'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		calm = 0;
		arst_n = 0;
		cur_x = 0;
		cur_y = 0;
		cfg_we <= 0;
		cfg_index <= '0;
		cfg_data <= '0;
		item_ch.valid <= 0;
		item_ch.kind <= 0;
		item_ch.cursor_x <= '0;
		item_ch.cursor_y <= '0;
		item_ch.key_forward <= 0;
		item_ch.key_back <= 0;
		item_ch.key_left <= 0;
		item_ch.key_right <= 0;
		item_ch.frame_time <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// ticks before any cursor word, then the first cursor word only sets the reference
		tick(4'b1000, 16'hFFFF);
		tick(4'b0011, 16'd16667);
		look(16'sh8000, 16'sh7FFF);
		look(16'sh7FFF, 16'sh8000);
		look(16'sh8000, 16'sh7FFF);
		tick(4'b1100, 16'd1000);
		tick(4'b1111, 16'hFFFF);
		tick(4'b0000, 16'd0);
		tick(4'b0100, 16'd33333);
		tick(4'b0010, 16'd5000);
		settle();

		// extremes, limit beyond ninety degrees
		set_all(4095, 32767, 65535);
		look(16'sd0, 16'sd0);
		look(16'sd100, -16'sd30);
		look(-16'sd200, 16'sd50);
		tick(4'b1001, 16'hFFFF);
		tick(4'b0110, 16'hFFFF);
		look(16'sd17, -16'sd3000);
		settle();

		// limit lowered while pitch is large: clamp waits for the next cursor word
		set_all(0, 0, 0);
		tick(4'b1111, 16'hFFFF);
		look(16'sd300, 16'sd300);
		tick(4'b1000, 16'hFFFF);
		settle();

		set_all(2560, 22784, 640);
		random_words(270);
		settle();
		calm = 1;
		set_all($urandom_range(2560), $urandom_range(22784), $urandom);
		random_words(270);
		settle();
		calm = 0;
		set_all($urandom_range(4095), $urandom_range(32767), $urandom);
		random_words(270);
		settle();
		set_all(26, 22784, 640);
		random_words(270);
		settle();

		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[mouse_look_camera_step.f]
+incdir+hdl
hdl/mlc_pkg.sv
hdl/mlc_item_if.sv
hdl/mlc_result_if.sv
hdl/mlc_serial_mul.sv
hdl/mlc_const_div.sv
hdl/mlc_cordic.sv
hdl/mouse_look_camera_step.sv
tb/mlc_checker.sv
tb/tb_mouse_look_camera_step.sv
